>>> hw/rtl/shamir_pkg.sv
package shamir_pkg;

    localparam int MAX_SHARES_DEF = 16;
    localparam int CNT_W          = 5;
    localparam int STEP_W         = 3;

    localparam logic [CNT_W-1:0]  SHARE_COUNT_RST = 5'd2;
    localparam logic [7:0]        GF_POLY         = 8'h1b;
    localparam logic [7:0]        GF_MSB          = 8'h80;
    localparam logic [STEP_W-1:0] INV_LAST        = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHARE,
        ST_RD_XI,
        ST_LD_XI,
        ST_ACC,
        ST_SQ,
        ST_INV,
        ST_WGT
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_SHARE,
        OP_RD_XI,
        OP_LD_XI,
        OP_ACC,
        OP_SQ,
        OP_INV,
        OP_WGT
    } dp_op_t;

    typedef struct packed {
        logic   accept;
        dp_op_t op;
    } cmd_t;

    typedef struct packed {
        logic k_zero;
        logic i_last;
        logic j_last;
        logic inv_done;
        logic last_reg;
        logic out_busy;
    } status_t;

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] aa;
        p  = '0;
        aa = a;
        for (int n = 0; n < 8; n++) begin
            if (b[n]) begin
                p = p ^ aa;
            end
            if ((aa & GF_MSB) != '0) begin
                aa = (aa << 1) ^ GF_POLY;
            end else begin
                aa = aa << 1;
            end
        end
        return p;
    endfunction

endpackage

>>> hw/rtl/shamir_ram.sv
module shamir_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/shamir_ctrl.sv
module shamir_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_func,
    input  logic                s_last_share,
    input  shamir_pkg::status_t status,
    output shamir_pkg::cmd_t    cmd
);

    shamir_pkg::state_t state_reg;
    shamir_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= shamir_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            shamir_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_func) begin
                        state_next = shamir_pkg::ST_SHARE;
                    end else if (s_last_share && !status.k_zero) begin
                        state_next = shamir_pkg::ST_RD_XI;
                    end
                end
            end
            shamir_pkg::ST_SHARE: begin
                if (!(status.last_reg && status.out_busy)) begin
                    state_next = shamir_pkg::ST_IDLE;
                end
            end
            shamir_pkg::ST_RD_XI: state_next = shamir_pkg::ST_LD_XI;
            shamir_pkg::ST_LD_XI: state_next = shamir_pkg::ST_ACC;
            shamir_pkg::ST_ACC: begin
                if (status.j_last) begin
                    state_next = shamir_pkg::ST_SQ;
                end
            end
            shamir_pkg::ST_SQ: state_next = shamir_pkg::ST_INV;
            shamir_pkg::ST_INV: begin
                if (status.inv_done) begin
                    state_next = shamir_pkg::ST_WGT;
                end
            end
            shamir_pkg::ST_WGT: begin
                if (status.i_last) begin
                    state_next = shamir_pkg::ST_IDLE;
                end else begin
                    state_next = shamir_pkg::ST_RD_XI;
                end
            end
            default: state_next = shamir_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = (state_reg == shamir_pkg::ST_IDLE);
        cmd.accept = s_ready && s_valid;
        case (state_reg)
            shamir_pkg::ST_SHARE: begin
                if (status.last_reg && status.out_busy) begin
                    cmd.op = shamir_pkg::OP_NONE;
                end else begin
                    cmd.op = shamir_pkg::OP_SHARE;
                end
            end
            shamir_pkg::ST_RD_XI: cmd.op = shamir_pkg::OP_RD_XI;
            shamir_pkg::ST_LD_XI: cmd.op = shamir_pkg::OP_LD_XI;
            shamir_pkg::ST_ACC:   cmd.op = shamir_pkg::OP_ACC;
            shamir_pkg::ST_SQ:    cmd.op = shamir_pkg::OP_SQ;
            shamir_pkg::ST_INV:   cmd.op = shamir_pkg::OP_INV;
            shamir_pkg::ST_WGT:   cmd.op = shamir_pkg::OP_WGT;
            default:              cmd.op = shamir_pkg::OP_NONE;
        endcase
    end

endmodule

>>> hw/rtl/shamir_dp.sv
module shamir_dp #(
    parameter int MAX_SHARES = shamir_pkg::MAX_SHARES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  shamir_pkg::cmd_t            cmd,
    output shamir_pkg::status_t         status,
    input  logic                        s_func,
    input  logic [3:0]                  s_slot,
    input  logic [7:0]                  s_x_coord,
    input  logic [7:0]                  s_y_byte,
    input  logic                        s_last_share,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [7:0]                  m_recovered_byte,
    input  logic                        cfg_we,
    input  logic [shamir_pkg::CNT_W-1:0] cfg_data
);

    localparam int AW = $clog2(MAX_SHARES);
    localparam int KW = $clog2(MAX_SHARES + 1);
    localparam int CW = (KW > shamir_pkg::CNT_W) ? KW : shamir_pkg::CNT_W;
    localparam int SW = shamir_pkg::STEP_W;

    logic [shamir_pkg::CNT_W-1:0]  share_count_reg;
    logic [CW-1:0]                 k;
    logic [CW-1:0]                 k_last;
    logic                          slot_active;
    logic [AW-1:0]                 i_reg;
    logic [AW-1:0]                 j_reg;
    logic [shamir_pkg::STEP_W-1:0] step_reg;
    logic [7:0]                    xi_reg;
    logic [7:0]                    num_reg;
    logic [7:0]                    den_reg;
    logic [7:0]                    inv_reg;
    logic [7:0]                    y_reg;
    logic [7:0]                    acc_reg;
    logic [7:0]                    secret_reg;
    logic                          last_reg;
    logic                          active_reg;
    logic                          m_valid_reg;
    logic                          emit;
    logic                          i_last;
    logic                          j_last;
    logic [7:0]                    ma_a;
    logic [7:0]                    ma_b;
    logic [7:0]                    ma_p;
    logic [7:0]                    mb_a;
    logic [7:0]                    mb_b;
    logic [7:0]                    mb_p;
    logic [7:0]                    share_prod;
    logic                          crd_re;
    logic [AW-1:0]                 crd_addr;
    logic [7:0]                    crd;
    logic [7:0]                    wrd;

    assign k = (CW'(share_count_reg) > CW'(MAX_SHARES)) ? CW'(MAX_SHARES)
                                                         : CW'(share_count_reg);
    assign k_last      = k - CW'(1);
    assign slot_active = CW'(s_slot) < k;
    assign i_last      = CW'(i_reg) == k_last;
    assign j_last      = CW'(j_reg) == k_last;
    assign emit        = (cmd.op == shamir_pkg::OP_SHARE) && last_reg;

    always_comb begin
        case (cmd.op)
            shamir_pkg::OP_SHARE: begin
                ma_a = y_reg;
                ma_b = wrd;
            end
            shamir_pkg::OP_ACC: begin
                ma_a = num_reg;
                ma_b = crd;
            end
            shamir_pkg::OP_INV: begin
                ma_a = inv_reg;
                ma_b = den_reg;
            end
            default: begin
                ma_a = num_reg;
                ma_b = inv_reg;
            end
        endcase
        mb_a = den_reg;
        if (cmd.op == shamir_pkg::OP_ACC) begin
            mb_b = xi_reg ^ crd;
        end else begin
            mb_b = den_reg;
        end
    end

    assign ma_p       = shamir_pkg::gf_mul(ma_a, ma_b);
    assign mb_p       = shamir_pkg::gf_mul(mb_a, mb_b);
    assign share_prod = active_reg ? ma_p : 8'h00;

    always_comb begin
        crd_re = cmd.op inside {shamir_pkg::OP_RD_XI, shamir_pkg::OP_LD_XI, shamir_pkg::OP_ACC};
        case (cmd.op)
            shamir_pkg::OP_LD_XI: crd_addr = '0;
            shamir_pkg::OP_ACC:   crd_addr = j_last ? j_reg : j_reg + AW'(1);
            default:              crd_addr = i_reg;
        endcase
    end

    shamir_ram #(
        .WIDTH (8),
        .DEPTH (MAX_SHARES)
    ) u_coord_ram (
        .aclk  (aclk),
        .we    (cmd.accept && !s_func && slot_active),
        .waddr (AW'(s_slot)),
        .wdata (s_x_coord),
        .re    (crd_re),
        .raddr (crd_addr),
        .rdata (crd)
    );

    shamir_ram #(
        .WIDTH (8),
        .DEPTH (MAX_SHARES)
    ) u_weight_ram (
        .aclk  (aclk),
        .we    (cmd.op == shamir_pkg::OP_WGT),
        .waddr (i_reg),
        .wdata (ma_p),
        .re    (cmd.accept && s_func),
        .raddr (AW'(s_slot)),
        .rdata (wrd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            share_count_reg <= shamir_pkg::SHARE_COUNT_RST;
            acc_reg         <= '0;
            m_valid_reg     <= 1'b0;
            last_reg        <= 1'b0;
            i_reg           <= '0;
            j_reg           <= '0;
            step_reg        <= '0;
        end else begin
            if (cfg_we) begin
                share_count_reg <= cfg_data;
            end
            if (cmd.accept) begin
                last_reg <= s_last_share;
                i_reg    <= '0;
            end
            if (cmd.op == shamir_pkg::OP_SHARE) begin
                acc_reg <= last_reg ? 8'h00 : (acc_reg ^ share_prod);
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (cmd.op)
                shamir_pkg::OP_LD_XI: j_reg <= '0;
                shamir_pkg::OP_ACC: begin
                    if (!j_last) begin
                        j_reg <= j_reg + AW'(1);
                    end
                end
                shamir_pkg::OP_SQ:  step_reg <= '0;
                shamir_pkg::OP_INV: step_reg <= step_reg + SW'(1);
                shamir_pkg::OP_WGT: begin
                    if (!i_last) begin
                        i_reg <= i_reg + AW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            y_reg      <= s_y_byte;
            active_reg <= slot_active;
        end
        if (emit) begin
            secret_reg <= acc_reg ^ share_prod;
        end
        case (cmd.op)
            shamir_pkg::OP_LD_XI: begin
                xi_reg  <= crd;
                num_reg <= 8'h01;
                den_reg <= 8'h01;
            end
            shamir_pkg::OP_ACC: begin
                if (j_reg != i_reg) begin
                    num_reg <= ma_p;
                    den_reg <= mb_p;
                end
            end
            shamir_pkg::OP_SQ: begin
                den_reg <= mb_p;
                inv_reg <= 8'h01;
            end
            shamir_pkg::OP_INV: begin
                den_reg <= mb_p;
                inv_reg <= ma_p;
            end
            default: ;
        endcase
    end

    assign m_valid          = m_valid_reg;
    assign m_recovered_byte = secret_reg;

    always_comb begin
        status.k_zero   = (k == '0);
        status.i_last   = i_last;
        status.j_last   = j_last;
        status.inv_done = (step_reg == shamir_pkg::INV_LAST);
        status.last_reg = last_reg;
        status.out_busy = m_valid_reg && !m_ready;
    end

`ifndef SYNTHESIS
    a_acc_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> (acc_reg == 8'h00))
        else $error("accumulator not cleared after emit");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> !(m_valid_reg && !m_ready))
        else $error("result overwritten while stalled");

    a_wgt_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == shamir_pkg::OP_WGT) |-> (CW'(i_reg) <= k_last))
        else $error("weight write beyond active slots");

    a_acc_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == shamir_pkg::OP_ACC) |-> (CW'(j_reg) <= k_last))
        else $error("coordinate scan beyond active slots");
`endif

endmodule

>>> hw/rtl/shamir_gf256_reconstruct.sv
// Shamir secret reconstruction over GF(2^8), polynomial 0x11b, interpolated at x = 0.
// A coordinate request (func 0) marked last also runs the weight pass when k is
// nonzero, which for k active slots does one coordinate RAM read per term and a
// 7-step square-and-multiply inversion per weight. A share-byte request (func 1)
// does a registered weight RAM read, then one GF multiply and XOR into the
// accumulator. The result sits in an output register, so new requests are taken
// while it waits; only a last share byte holds until that register is free.
// Duplicate x values give weight zero. cfg_data sets share_count; it must be
// written only while the block is idle, and the block itself does not enforce this.
module shamir_gf256_reconstruct #(
    parameter int MAX_SHARES = shamir_pkg::MAX_SHARES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_func,
    input  logic [3:0]                   s_slot,
    input  logic [7:0]                   s_x_coord,
    input  logic [7:0]                   s_y_byte,
    input  logic                         s_last_share,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [7:0]                   m_recovered_byte,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [shamir_pkg::CNT_W-1:0] cfg_data
);

    shamir_pkg::cmd_t    cmd;
    shamir_pkg::status_t status;

    assign cfg_ready = 1'b1;

    shamir_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_last_share (s_last_share),
        .status       (status),
        .cmd          (cmd)
    );

    shamir_dp #(
        .MAX_SHARES (MAX_SHARES)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .s_func           (s_func),
        .s_slot           (s_slot),
        .s_x_coord        (s_x_coord),
        .s_y_byte         (s_y_byte),
        .s_last_share     (s_last_share),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_recovered_byte (m_recovered_byte),
        .cfg_we           (cfg_valid && cfg_ready),
        .cfg_data         (cfg_data)
    );

endmodule
